// ===== rtl/dstat_pkg.sv =====
// shared types, constants and command codes for the descriptive statistics block
package dstat_pkg;

  localparam int unsigned MAX_COUNT = 65535;
  localparam int unsigned COUNT_W = 16;
  localparam int unsigned SUM_W = 32;
  localparam int unsigned SUMSQ_W = 46;
  localparam int unsigned SQ_HALF_W = 23;
  localparam int unsigned VAR_W = 62;
  localparam int unsigned DIVISOR_W = 32;
  localparam int unsigned DIV_STEPS = 62;
  localparam int unsigned DIV_CNT_W = 6;
  localparam int unsigned ROOT_W = 32;
  localparam logic [ROOT_W-1:0] SQRT_BIT_INIT = 32'h4000_0000;

  // multiplier operand select
  localparam logic [1:0] MUL_NSQ_LO = 2'd0;
  localparam logic [1:0] MUL_NSQ_HI = 2'd1;
  localparam logic [1:0] MUL_MAG = 2'd2;
  localparam logic [1:0] MUL_NN = 2'd3;

  // variance numerator register update
  localparam logic [1:0] V_HOLD = 2'd0;
  localparam logic [1:0] V_LOAD = 2'd1;
  localparam logic [1:0] V_ADDSH = 2'd2;
  localparam logic [1:0] V_SUB = 2'd3;

  typedef struct packed {
    logic signed [15:0] sample;
    logic last;
  } sample_beat_t;

  typedef struct packed {
    logic signed [15:0] max_value;
    logic signed [15:0] min_value;
    logic [15:0] range_value;
    logic signed [15:0] mean_value;
    logic [14:0] std_dev;
    logic [15:0] sample_count;
    logic overflow;
  } result_beat_t;

  typedef struct packed {
    logic acc_en;
    logic [1:0] mul_sel;
    logic [1:0] v_op;
    logic div_start;
    logic div_mean;
    logic sqrt_start;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic div_done;
    logic sqrt_done;
    logic out_free;
  } status_t;

endpackage

// ===== rtl/descriptive_statistics_top.sv =====
// top level of the descriptive statistics block
// accumulation takes one sample beat per cycle with no stall between beats
// after the beat marked last the input stalls; the result beat appears once the
// result register is free (multiply steps, two 62-step divides,
// 16-step square root), then a new set is accepted at once
// synchronous reset clears the accumulators, controller and result valid
module descriptive_statistics_top (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    sample_valid,
  output logic                    sample_stall,
  input  dstat_pkg::sample_beat_t sample_data,
  output logic                    result_valid,
  input  logic                    result_stall,
  output dstat_pkg::result_beat_t result_data
);

  dstat_pkg::cmd_t cmd;
  dstat_pkg::status_t status;

  dstat_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_valid),
    .sample_last  (sample_data.last),
    .status       (status),
    .sample_stall (sample_stall),
    .cmd          (cmd)
  );

  dstat_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .sample_data  (sample_data),
    .cmd          (cmd),
    .status       (status),
    .result_stall (result_stall),
    .result_valid (result_valid),
    .result_data  (result_data)
  );

  a_last_stalls: assert property (@(posedge clk) disable iff (rst)
    (sample_valid && !sample_stall && sample_data.last) |=> sample_stall)
    else $error("input not stalled after last beat");

  a_result_from_busy: assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> $past(sample_stall))
    else $error("result beat raised while accumulating");

  a_range_consistent: assert property (@(posedge clk) disable iff (rst)
    result_valid |->
      result_data.range_value == 16'(result_data.max_value - result_data.min_value))
    else $error("range does not match max and min");

  a_min_le_max: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> result_data.min_value <= result_data.max_value)
    else $error("min above max");

endmodule

// ===== rtl/dstat_div.sv =====
// iterative restoring divider, one quotient bit per cycle
module dstat_div (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  input  logic [dstat_pkg::VAR_W-1:0]       dividend,
  input  logic [dstat_pkg::DIVISOR_W-1:0]   divisor,
  output logic                              done,
  output logic [dstat_pkg::VAR_W-1:0]       quotient,
  output logic [dstat_pkg::DIVISOR_W-1:0]   remainder
);

  logic [dstat_pkg::DIVISOR_W-1:0] dsr;
  logic [dstat_pkg::DIV_CNT_W-1:0] step;
  logic busy;
  logic [dstat_pkg::DIVISOR_W:0] trial;
  logic [dstat_pkg::DIVISOR_W:0] diff;
  logic ge;

  assign trial = {remainder, quotient[dstat_pkg::VAR_W-1]};
  assign ge = trial >= {1'b0, dsr};
  assign diff = trial - {1'b0, dsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else if (start) begin
      busy <= 1'b1;
      done <= 1'b0;
      step <= '0;
    end else if (busy) begin
      step <= step + 1'b1;
      if (step == dstat_pkg::DIV_CNT_W'(dstat_pkg::DIV_STEPS - 1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end else begin
      done <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quotient <= dividend;
      remainder <= '0;
      dsr <= divisor;
    end else if (busy) begin
      remainder <= ge ? diff[dstat_pkg::DIVISOR_W-1:0] : trial[dstat_pkg::DIVISOR_W-1:0];
      quotient <= {quotient[dstat_pkg::VAR_W-2:0], ge};
    end
  end

endmodule

// ===== rtl/dstat_ctrl.sv =====
// controller state machine: accumulate, multiply, divide, square root, divide for the mean, output
module dstat_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               sample_valid,
  input  logic               sample_last,
  input  dstat_pkg::status_t status,
  output logic               sample_stall,
  output dstat_pkg::cmd_t    cmd
);

  localparam logic [3:0] S_ACC = 4'd0;
  localparam logic [3:0] S_M0 = 4'd1;
  localparam logic [3:0] S_M1 = 4'd2;
  localparam logic [3:0] S_M2 = 4'd3;
  localparam logic [3:0] S_M3 = 4'd4;
  localparam logic [3:0] S_M4 = 4'd5;
  localparam logic [3:0] S_DV = 4'd6;
  localparam logic [3:0] S_SQ = 4'd7;
  localparam logic [3:0] S_DM = 4'd8;
  localparam logic [3:0] S_FIN = 4'd9;

  logic [3:0] state;
  logic [3:0] state_next;
  logic beat;

  assign sample_stall = (state != S_ACC);
  assign beat = sample_valid && (state == S_ACC);

  always_comb begin
    state_next = state;
    cmd = '0;
    cmd.mul_sel = dstat_pkg::MUL_NN;
    cmd.v_op = dstat_pkg::V_HOLD;
    unique case (state)
      S_ACC: begin
        cmd.acc_en = beat;
        if (beat && sample_last) state_next = S_M0;
      end
      S_M0: begin
        cmd.mul_sel = dstat_pkg::MUL_NSQ_LO;
        state_next = S_M1;
      end
      S_M1: begin
        cmd.mul_sel = dstat_pkg::MUL_NSQ_HI;
        cmd.v_op = dstat_pkg::V_LOAD;
        state_next = S_M2;
      end
      S_M2: begin
        cmd.mul_sel = dstat_pkg::MUL_MAG;
        cmd.v_op = dstat_pkg::V_ADDSH;
        state_next = S_M3;
      end
      S_M3: begin
        cmd.mul_sel = dstat_pkg::MUL_NN;
        cmd.v_op = dstat_pkg::V_SUB;
        state_next = S_M4;
      end
      S_M4: begin
        cmd.div_start = 1'b1;
        state_next = S_DV;
      end
      S_DV: begin
        if (status.div_done) begin
          cmd.sqrt_start = 1'b1;
          state_next = S_SQ;
        end
      end
      S_SQ: begin
        if (status.sqrt_done) begin
          cmd.div_start = 1'b1;
          cmd.div_mean = 1'b1;
          state_next = S_DM;
        end
      end
      S_DM: begin
        if (status.div_done) state_next = S_FIN;
      end
      S_FIN: begin
        if (status.out_free) begin
          cmd.out_load = 1'b1;
          state_next = S_ACC;
        end
      end
      default: state_next = S_ACC;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_ACC;
    end else begin
      state <= state_next;
    end
  end

endmodule

// ===== rtl/dstat_dp.sv =====
// datapath: accumulators, shared multiplier, divider, square root, result register
module dstat_dp (
  input  logic                    clk,
  input  logic                    rst,
  input  dstat_pkg::sample_beat_t sample_data,
  input  dstat_pkg::cmd_t         cmd,
  output dstat_pkg::status_t      status,
  input  logic                    result_stall,
  output logic                    result_valid,
  output dstat_pkg::result_beat_t result_data
);

  logic [dstat_pkg::COUNT_W-1:0] count_so_far;
  logic signed [15:0] running_max;
  logic signed [15:0] running_min;
  logic signed [dstat_pkg::SUM_W-1:0] running_sum;
  logic [dstat_pkg::SUMSQ_W-1:0] running_sum_sq;
  logic overflow_seen;

  logic signed [31:0] sq_s;
  logic [dstat_pkg::SUM_W-1:0] mag;
  logic [31:0] mul_a;
  logic [31:0] mul_b;
  logic [63:0] prod;
  logic [dstat_pkg::VAR_W-1:0] var_num;

  logic [dstat_pkg::VAR_W-1:0] div_dividend;
  logic [dstat_pkg::DIVISOR_W-1:0] div_divisor;
  logic div_done;
  logic [dstat_pkg::VAR_W-1:0] div_quo;
  logic [dstat_pkg::DIVISOR_W-1:0] div_rem;

  logic [dstat_pkg::ROOT_W-1:0] sq_val;
  logic [dstat_pkg::ROOT_W-1:0] sq_root;
  logic [dstat_pkg::ROOT_W-1:0] sq_bit;
  logic sq_busy;
  logic sq_done;
  logic [dstat_pkg::ROOT_W:0] sq_sum;
  logic sq_ge;

  logic [15:0] mean;
  logic count_zero;

  // accumulation
  assign sq_s = sample_data.sample * sample_data.sample;

  always_ff @(posedge clk) begin
    if (rst || cmd.out_load) begin
      count_so_far <= '0;
      running_max <= '0;
      running_min <= '0;
      running_sum <= '0;
      running_sum_sq <= '0;
      overflow_seen <= 1'b0;
    end else if (cmd.acc_en) begin
      if (count_so_far < dstat_pkg::COUNT_W'(dstat_pkg::MAX_COUNT)) begin
        if (count_so_far == '0) begin
          running_max <= sample_data.sample;
          running_min <= sample_data.sample;
        end else begin
          if (sample_data.sample > running_max) running_max <= sample_data.sample;
          if (sample_data.sample < running_min) running_min <= sample_data.sample;
        end
        running_sum <= running_sum + {{16{sample_data.sample[15]}}, sample_data.sample};
        running_sum_sq <= running_sum_sq + {14'b0, sq_s};
        count_so_far <= count_so_far + 1'b1;
      end else begin
        overflow_seen <= 1'b1;
      end
    end
  end

  // shared multiplier and variance numerator n*sumsq - sum^2
  assign mag = running_sum[dstat_pkg::SUM_W-1] ? -running_sum : running_sum;

  always_comb begin
    case (cmd.mul_sel)
      dstat_pkg::MUL_NSQ_LO: begin
        mul_a = {16'b0, count_so_far};
        mul_b = {9'b0, running_sum_sq[dstat_pkg::SQ_HALF_W-1:0]};
      end
      dstat_pkg::MUL_NSQ_HI: begin
        mul_a = {16'b0, count_so_far};
        mul_b = {9'b0, running_sum_sq[dstat_pkg::SUMSQ_W-1:dstat_pkg::SQ_HALF_W]};
      end
      dstat_pkg::MUL_MAG: begin
        mul_a = mag;
        mul_b = mag;
      end
      default: begin
        mul_a = {16'b0, count_so_far};
        mul_b = {16'b0, count_so_far};
      end
    endcase
  end

  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
    case (cmd.v_op)
      dstat_pkg::V_LOAD: var_num <= prod[dstat_pkg::VAR_W-1:0];
      dstat_pkg::V_ADDSH: var_num <= var_num + {prod[38:0], 23'b0};
      dstat_pkg::V_SUB: var_num <= var_num - prod[dstat_pkg::VAR_W-1:0];
      default: var_num <= var_num;
    endcase
  end

  // divider shared by variance and mean
  assign div_dividend = cmd.div_mean ? {30'b0, mag} : var_num;
  assign div_divisor = cmd.div_mean ? {16'b0, count_so_far} : prod[dstat_pkg::DIVISOR_W-1:0];

  dstat_div u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (cmd.div_start),
    .dividend  (div_dividend),
    .divisor   (div_divisor),
    .done      (div_done),
    .quotient  (div_quo),
    .remainder (div_rem)
  );

  // integer square root, two bits of the radicand per cycle
  assign sq_sum = {1'b0, sq_root} + {1'b0, sq_bit};
  assign sq_ge = {1'b0, sq_val} >= sq_sum;

  always_ff @(posedge clk) begin
    if (rst) begin
      sq_busy <= 1'b0;
      sq_done <= 1'b0;
    end else if (cmd.sqrt_start) begin
      sq_busy <= 1'b1;
      sq_done <= 1'b0;
    end else if (sq_busy) begin
      if (sq_bit == dstat_pkg::ROOT_W'(1)) begin
        sq_busy <= 1'b0;
        sq_done <= 1'b1;
      end
    end else begin
      sq_done <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.sqrt_start) begin
      sq_val <= div_quo[dstat_pkg::ROOT_W-1:0];
      sq_root <= '0;
      sq_bit <= dstat_pkg::SQRT_BIT_INIT;
    end else if (sq_busy) begin
      if (sq_ge) begin
        sq_val <= sq_val - sq_sum[dstat_pkg::ROOT_W-1:0];
        sq_root <= (sq_root >> 1) + sq_bit;
      end else begin
        sq_root <= sq_root >> 1;
      end
      sq_bit <= sq_bit >> 2;
    end
  end

  // floored mean from magnitude quotient
  assign mean = running_sum[dstat_pkg::SUM_W-1]
              ? (~div_quo[15:0] + {15'b0, (div_rem == '0)})
              : div_quo[15:0];
  assign count_zero = (count_so_far == '0);

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (cmd.out_load) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      if (count_zero) begin
        result_data.max_value <= '0;
        result_data.min_value <= '0;
        result_data.range_value <= '0;
        result_data.mean_value <= '0;
        result_data.std_dev <= '0;
        result_data.sample_count <= '0;
      end else begin
        result_data.max_value <= running_max;
        result_data.min_value <= running_min;
        result_data.range_value <= running_max - running_min;
        result_data.mean_value <= mean;
        result_data.std_dev <= sq_root[14:0];
        result_data.sample_count <= count_so_far;
      end
      result_data.overflow <= overflow_seen;
    end
  end

  assign status.div_done = div_done;
  assign status.sqrt_done = sq_done;
  assign status.out_free = !result_valid || !result_stall;

endmodule
